// ----- design/u2a_pkg.sv -----
// Shared types, constants and helpers for the 64-bit value to ASCII digit converter.
// No dependencies; imported by every module of the block.
package u2a_pkg;

  localparam int unsigned VALUE_BITS_DEF     = 64;
  localparam int unsigned DECIMAL_DIGITS_DEF = 20;

  localparam logic [4:0] BASE_BIN = 5'd2;
  localparam logic [4:0] BASE_DEC = 5'd10;
  localparam logic [4:0] BASE_HEX = 5'd16;

  localparam logic [6:0] CHAR_ZERO     = 7'h30;
  localparam logic [6:0] CHAR_A_LESS10 = 7'h57;
  localparam logic [6:0] CHAR_NONE     = 7'h00;

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  number_base;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
    logic       error;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_HEX = 2'd0,
    MODE_BIN = 2'd1,
    MODE_DEC = 2'd2,
    MODE_ERR = 2'd3
  } mode_e;

  typedef struct packed {
    logic  load;
    logic  dec_step;
    logic  skip;
    logic  emit;
    logic  last;
    mode_e mode;
  } cmd_t;

  typedef struct packed {
    logic top_zero;
    logic slot_free;
  } status_t;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    logic [6:0] code;
    if (d <= 4'd9) begin
      code = CHAR_ZERO + {3'b000, d};
    end else begin
      code = CHAR_A_LESS10 + {3'b000, d};
    end
    return code;
  endfunction

endpackage

// ----- design/u2a_ctrl.sv -----
// Sequencer of the converter: picks the mode, counts conversion, skip and emit steps.
// Depends on u2a_pkg; drives the datapath u2a_dp through cmd_t and reads status_t.
module u2a_ctrl import u2a_pkg::*; #(
  parameter int unsigned VALUE_BITS     = VALUE_BITS_DEF,
  parameter int unsigned DECIMAL_DIGITS = DECIMAL_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] number_base_i,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  localparam int unsigned HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int unsigned CNT_MAX    = (VALUE_BITS > DECIMAL_DIGITS) ? VALUE_BITS
                                                                      : DECIMAL_DIGITS;
  localparam int unsigned CW         = $clog2(CNT_MAX + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  mode_e         mode_q, mode_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mode = mode_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          priority if (number_base_i == BASE_HEX) begin
            mode_d  = MODE_HEX;
            cnt_d   = CW'(HEX_DIGITS);
            state_d = S_EMIT;
          end else if (number_base_i == BASE_BIN) begin
            mode_d  = MODE_BIN;
            cnt_d   = CW'(VALUE_BITS);
            state_d = S_EMIT;
          end else if (number_base_i == BASE_DEC) begin
            mode_d  = MODE_DEC;
            cnt_d   = CW'(VALUE_BITS);
            state_d = S_CONV;
          end else begin
            mode_d  = MODE_ERR;
            cnt_d   = CW'(1);
            state_d = S_EMIT;
          end
        end
      end
      S_CONV: begin
        cmd_o.dec_step = 1'b1;
        if (cnt_q == CW'(1)) begin
          cnt_d   = CW'(DECIMAL_DIGITS);
          state_d = S_SKIP;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      S_SKIP: begin
        if (status_i.top_zero && (cnt_q != CW'(1))) begin
          cmd_o.skip = 1'b1;
          cnt_d      = cnt_q - CW'(1);
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = (cnt_q == CW'(1));
          cnt_d      = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_HEX;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.slot_free)
    else $error("emit issued while output slot is occupied");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.dec_step, cmd_o.skip, cmd_o.emit}))
    else $error("more than one datapath command in a cycle");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after the last character");

  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.dec_step || cmd_o.emit) |-> (cnt_q != '0))
    else $error("step issued with an exhausted counter");

endmodule

// ----- design/u2a_dp.sv -----
// Datapath of the converter: value shift register, BCD register and output item register.
// Depends on u2a_pkg; steered by u2a_ctrl through cmd_t, reports status_t.
module u2a_dp import u2a_pkg::*; #(
  parameter int unsigned VALUE_BITS     = VALUE_BITS_DEF,
  parameter int unsigned DECIMAL_DIGITS = DECIMAL_DIGITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [63:0] value_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int unsigned SW         = 4 * HEX_DIGITS;
  localparam int unsigned BW         = 4 * DECIMAL_DIGITS;

  logic [SW-1:0] sr_q, sr_d;
  logic [BW-1:0] bcd_q, bcd_d;
  logic [BW-1:0] bcd_adj;
  out_item_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    for (int i = 0; i < DECIMAL_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign status_o.top_zero  = (bcd_q[BW-1 -: 4] == 4'd0);
  assign status_o.slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    sr_d        = sr_q;
    bcd_d       = bcd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      sr_d  = SW'(value_i[VALUE_BITS-1:0]);
      bcd_d = '0;
    end
    if (cmd_i.dec_step) begin
      bcd_d = {bcd_adj[BW-2:0], sr_q[VALUE_BITS-1]};
      sr_d  = sr_q << 1;
    end
    if (cmd_i.skip) begin
      bcd_d = bcd_q << 4;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_d.last  = cmd_i.last;
      out_d.error = 1'b0;
      unique case (cmd_i.mode)
        MODE_HEX: begin
          out_d.char_code = hex_char(sr_q[SW-1 -: 4]);
          sr_d            = sr_q << 4;
        end
        MODE_BIN: begin
          out_d.char_code = CHAR_ZERO + {6'd0, sr_q[VALUE_BITS-1]};
          sr_d            = sr_q << 1;
        end
        MODE_DEC: begin
          out_d.char_code = CHAR_ZERO + {3'd0, bcd_q[BW-1 -: 4]};
          bcd_d           = bcd_q << 4;
        end
        MODE_ERR: begin
          out_d.char_code = CHAR_NONE;
          out_d.error     = 1'b1;
        end
        default: begin
          out_d.char_code = CHAR_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q  <= sr_d;
    bcd_q <= bcd_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted character did not reach the output register");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.error) |-> (out_q.last && (out_q.char_code == CHAR_NONE)))
    else $error("error item must be a single empty character");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("pending output item changed while stalled");

endmodule

// ----- design/uint64_to_ascii_digits_top.sv -----
// Top level of the 64-bit value to ASCII digit converter.
// Depends on u2a_pkg; instantiates u2a_ctrl (sequencer) and u2a_dp (datapath).
//
// One item converts a value into ASCII digits, one character per output item, most
// significant first, the final one flagged by last. Base 16 and base 2 keep leading
// zeros and emit ceil(VALUE_BITS/4) or VALUE_BITS characters after taking the item.
// Base 10 takes the item, runs VALUE_BITS shift-and-adjust steps into a
// DECIMAL_DIGITS-digit BCD register, strips leading zeros one digit per cycle, then
// emits the remaining digits; stripped and emitted digits add up to DECIMAL_DIGITS.
// A zero value gives a single '0'; values at or above 10^DECIMAL_DIGITS wrap modulo
// that power. Any other base gives one item with error set and char_code 0.
// A new item is taken once the previous one has handed its last character to the
// output register; a stalled output holds the run until the output slot is free.
module uint64_to_ascii_digits_top import u2a_pkg::*; #(
  parameter int unsigned VALUE_BITS     = VALUE_BITS_DEF,
  parameter int unsigned DECIMAL_DIGITS = DECIMAL_DIGITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  cmd_t    cmd;
  status_t status;

  u2a_ctrl #(
    .VALUE_BITS    (VALUE_BITS),
    .DECIMAL_DIGITS(DECIMAL_DIGITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .number_base_i(in_item_i.number_base),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  u2a_dp #(
    .VALUE_BITS    (VALUE_BITS),
    .DECIMAL_DIGITS(DECIMAL_DIGITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (in_item_i.value),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- tb/sv/uint64_to_ascii_digits_top_test.sv -----
// Self-checking testbench for uint64_to_ascii_digits_top: predicts the digit characters of
// each accepted value and base, and checks every output item in order.
// Depends on u2a_pkg and the block's RTL only.
module uint64_to_ascii_digits_top_test;
  import u2a_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0] ASCII_ZERO    = 7'h30;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam int         NUM_DIGITS    = 20;
  localparam int         RANDOM_ITEMS  = 300;
  localparam int         CALM_ITEMS    = 60;
  localparam int         TAIL_CYCLES   = 120;
  localparam int         CYCLE_LIMIT   = 1500000;
  localparam int         MAX_PRINTS    = 30;

  class digit_scoreboard;
    out_item_t expected_chars[$];
    int        errors;

    function int pending();
      return expected_chars.size();
    endfunction

    function void push_char(logic [6:0] code, logic is_last, logic is_err);
      out_item_t c;
      c.char_code = code;
      c.last      = is_last;
      c.error     = is_err;
      expected_chars.push_back(c);
    endfunction

    function void note_input(in_item_t it);
      logic [63:0] rest;
      logic [3:0]  nibble;
      logic [3:0]  dec_digits [NUM_DIGITS];
      int          first;
      if (it.number_base == BASE_HEX) begin
        for (int i = 15; i >= 0; i--) begin
          nibble = it.value[4*i +: 4];
          push_char((nibble < 4'd10) ? ASCII_ZERO + 7'(nibble) : ASCII_LOWER_A + 7'(nibble - 4'd10),
                    i == 0, 1'b0);
        end
      end else if (it.number_base == BASE_BIN) begin
        for (int i = 63; i >= 0; i--) begin
          push_char(ASCII_ZERO + 7'(it.value[i]), i == 0, 1'b0);
        end
      end else if (it.number_base == BASE_DEC) begin
        rest = it.value;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
          dec_digits[i] = 4'(rest % 64'd10);
          rest = rest / 64'd10;
        end
        first = NUM_DIGITS - 1;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
          if (dec_digits[i] != 4'd0) first = i;
        end
        for (int i = first; i < NUM_DIGITS; i++) begin
          push_char(ASCII_ZERO + 7'(dec_digits[i]), i == NUM_DIGITS - 1, 1'b0);
        end
      end else begin
        push_char(CHAR_NONE, 1'b1, 1'b1);
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected item char=%h last=%b err=%b",
                                  got.char_code, got.last, got.error));
        return;
      end
      want = expected_chars.pop_front();
      if (got.char_code !== want.char_code)
        report_mismatch($sformatf("char_code %h, want %h", got.char_code, want.char_code));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      if (got.error !== want.error)
        report_mismatch($sformatf("error %b, want %b", got.error, want.error));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      idle_on   = 1'b1;
  int        cycles    = 0;

  digit_scoreboard sb = new();

  uint64_to_ascii_digits_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_item);
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task send_item(input logic [63:0] v, input logic [4:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item.value       <= v;
    in_item.number_base <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task send_random();
    logic [63:0] v;
    logic [4:0]  b;
    int          roll;
    v    = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 1) v = v >> $urandom_range(0, 63);
    if (roll < 8) begin
      do b = 5'($urandom_range(0, 31));
      while (b == BASE_BIN || b == BASE_DEC || b == BASE_HEX);
    end else if (roll < 55) begin
      b = BASE_DEC;
    end else if (roll < 80) begin
      b = BASE_HEX;
    end else begin
      b = BASE_BIN;
    end
    send_item(v, b);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(64'h0, BASE_HEX);
    send_item(64'hffff_ffff_ffff_ffff, BASE_HEX);
    send_item(64'h0123_4567_89ab_cdef, BASE_HEX);
    send_item(64'h0, BASE_BIN);
    send_item(64'hffff_ffff_ffff_ffff, BASE_BIN);
    send_item(64'haaaa_5555_f0f0_0f0f, BASE_BIN);
    send_item(64'd0, BASE_DEC);
    send_item(64'd1, BASE_DEC);
    send_item(64'd9, BASE_DEC);
    send_item(64'd10, BASE_DEC);
    send_item(64'd99, BASE_DEC);
    send_item(64'd9999999999999999999, BASE_DEC);
    send_item(64'd10000000000000000000, BASE_DEC);
    send_item(64'hffff_ffff_ffff_ffff, BASE_DEC);
    send_item(64'h8000_0000_0000_0000, BASE_DEC);
    send_item(64'h1234, 5'd0);
    send_item(64'hffff_ffff_ffff_ffff, 5'd31);
    send_item(64'h0, 5'd1);
    send_item(64'h5, 5'd3);
    send_item(64'h5, 5'd15);
    send_item(64'h5, 5'd17);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      if (i == RANDOM_ITEMS - CALM_ITEMS) idle_on <= 1'b0;
      send_random();
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
